// ===== sv/tri_tan_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tri_tan_pkg;

  // Widths of the external fields.
  localparam int unsigned FIELD_W = 32;

  // Default number format, signed Q16.16.
  localparam int unsigned COORD_BITS_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // Operand bits retired per multiplier step.
  localparam int unsigned CHUNK_W = 16;

  // Last product of a triangle: three tangent axes, two products each, after the determinant.
  localparam logic [2:0] LAST_STEP = 3'd7;
  localparam logic [1:0] CORNER_LAST = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LD,
    ST_MUL_RUN,
    ST_ACC,
    ST_DET_CHK,
    ST_DIV_LD,
    ST_DIV_RUN,
    ST_EMIT
  } tt_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic [1:0] corner;
    logic       mul_start;
    logic       mul_step;
    logic       acc_load;
    logic       acc_sub;
    logic [2:0] sel;
    logic       det_save;
    logic       div_start;
    logic       div_step;
    logic       axis_save;
    logic [1:0] axis;
    logic       emit;
  } tt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic det_zero;
  } tt_stat_t;

endpackage

`default_nettype wire

// ===== sv/tri_tan_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Vertex channel: one position and one texture coordinate per transfer.
interface tri_tan_vtx_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [tri_tan_pkg::FIELD_W-1:0]    pos_x;
  logic signed [tri_tan_pkg::FIELD_W-1:0]    pos_y;
  logic signed [tri_tan_pkg::FIELD_W-1:0]    pos_z;
  logic signed [tri_tan_pkg::FIELD_W-1:0]    tex_u;
  logic signed [tri_tan_pkg::FIELD_W-1:0]    tex_v;

  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

// Result channel: one tangent per triangle.
interface tri_tan_res_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [tri_tan_pkg::FIELD_W-1:0]    tangent_x;
  logic signed [tri_tan_pkg::FIELD_W-1:0]    tangent_y;
  logic signed [tri_tan_pkg::FIELD_W-1:0]    tangent_z;
  logic                                      degenerate;

  modport source (output valid, tangent_x, tangent_y, tangent_z, degenerate, input ready);
  modport sink   (input valid, tangent_x, tangent_y, tangent_z, degenerate, output ready);
endinterface

`default_nettype wire

// ===== sv/triangle_tangent_compute_unit.sv =====
// Per-triangle tangent unit, signed fixed point (Q16.16 by default).
// Channel vtx_i takes one vertex per transfer: position and texture coordinate.
// Every three vertices form a triangle; the first two are held, and the third
// starts the computation of one tangent that applies to all three corners.
// Channel res_o gives one transfer per triangle: tangent x, y, z, saturated to
// the coordinate range, and a degenerate flag that is set, with a zero tangent,
// when the texture determinant is zero. A trailing partial triangle gives nothing.
// A shared serial multiplier forms eight products, 16 bits a step, and a
// restoring divider gives one quotient bit a cycle per axis.
// The first two vertices of the next triangle are taken while a triangle is in
// work; its third vertex waits until the unit is idle, so the unit works on
// one triangle at a time.
// If the receiver stalls, the result waits in the output register; the unit
// still takes vertices and finishes the next triangle, then holds it until the
// output register is free. Reset clears the corner count, the sequencer and the
// result valid; held corners are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module triangle_tangent_compute_unit #(
  parameter int unsigned COORD_BITS = tri_tan_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = tri_tan_pkg::FRAC_BITS_DEF
) (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  tri_tan_vtx_if.sink    vtx_i,
  tri_tan_res_if.source  res_o
);

  tri_tan_pkg::tt_cmd_t  cmd;
  tri_tan_pkg::tt_stat_t stat;

  tri_tan_ctrl #(
    .COORD_BITS (COORD_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vtx_i.valid),
    .in_ready_o  (vtx_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tri_tan_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .pos_x_i      (vtx_i.pos_x),
    .pos_y_i      (vtx_i.pos_y),
    .pos_z_i      (vtx_i.pos_z),
    .tex_u_i      (vtx_i.tex_u),
    .tex_v_i      (vtx_i.tex_v),
    .tangent_x_o  (res_o.tangent_x),
    .tangent_y_o  (res_o.tangent_y),
    .tangent_z_o  (res_o.tangent_z),
    .degenerate_o (res_o.degenerate)
  );

endmodule

`default_nettype wire

// ===== sv/tri_tan_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tri_tan_datapath #(
  parameter int unsigned COORD_BITS = tri_tan_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = tri_tan_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                   clk_i,
  input  wire tri_tan_pkg::tt_cmd_t                   cmd_i,
  output      tri_tan_pkg::tt_stat_t                  stat_o,
  input  wire logic [tri_tan_pkg::FIELD_W-1:0]        pos_x_i,
  input  wire logic [tri_tan_pkg::FIELD_W-1:0]        pos_y_i,
  input  wire logic [tri_tan_pkg::FIELD_W-1:0]        pos_z_i,
  input  wire logic [tri_tan_pkg::FIELD_W-1:0]        tex_u_i,
  input  wire logic [tri_tan_pkg::FIELD_W-1:0]        tex_v_i,
  output      logic signed [tri_tan_pkg::FIELD_W-1:0] tangent_x_o,
  output      logic signed [tri_tan_pkg::FIELD_W-1:0] tangent_y_o,
  output      logic signed [tri_tan_pkg::FIELD_W-1:0] tangent_z_o,
  output      logic                                   degenerate_o
);

  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned DW  = C + 1;
  localparam int unsigned CHW = tri_tan_pkg::CHUNK_W;
  localparam int unsigned NCH = (DW + CHW - 1) / CHW;
  localparam int unsigned MBW = NCH * CHW;
  localparam int unsigned PAW = MBW + DW;
  localparam int unsigned PW  = 2 * C + 1;
  localparam int unsigned AW  = 2 * C + 3;
  localparam int unsigned NW  = AW + FRAC_BITS;
  localparam int unsigned FW  = tri_tan_pkg::FIELD_W;

  localparam logic signed [C-1:0] LIM_POS = {1'b0, {(C-1){1'b1}}};
  localparam logic signed [C-1:0] LIM_NEG = {1'b1, {(C-1){1'b0}}};

  // Incoming fields reduced to the coordinate width.
  logic signed [C-1:0] in_px, in_py, in_pz, in_u, in_v;
  logic signed [C-1:0] in_p [3];

  assign in_px = $signed(C'($unsigned(pos_x_i)));
  assign in_py = $signed(C'($unsigned(pos_y_i)));
  assign in_pz = $signed(C'($unsigned(pos_z_i)));
  assign in_u  = $signed(C'($unsigned(tex_u_i)));
  assign in_v  = $signed(C'($unsigned(tex_v_i)));
  assign in_p[0] = in_px;
  assign in_p[1] = in_py;
  assign in_p[2] = in_pz;

  // Held corners and the deltas of the current triangle.
  logic signed [C-1:0]  hp_q [2][3];
  logic signed [C-1:0]  hu_q [2];
  logic signed [C-1:0]  hv_q [2];
  logic signed [DW-1:0] dp1_q [3];
  logic signed [DW-1:0] dp2_q [3];
  logic signed [DW-1:0] du1_q, dv1_q, du2_q, dv2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && cmd_i.corner != tri_tan_pkg::CORNER_LAST) begin
      for (int k = 0; k < 3; k++) begin
        hp_q[cmd_i.corner[0]][k] <= in_p[k];
      end
      hu_q[cmd_i.corner[0]] <= in_u;
      hv_q[cmd_i.corner[0]] <= in_v;
    end
    if (cmd_i.load && cmd_i.corner == tri_tan_pkg::CORNER_LAST) begin
      for (int k = 0; k < 3; k++) begin
        dp1_q[k] <= DW'(hp_q[1][k]) - DW'(hp_q[0][k]);
        dp2_q[k] <= DW'(in_p[k]) - DW'(hp_q[0][k]);
      end
      du1_q <= DW'(hu_q[1]) - DW'(hu_q[0]);
      dv1_q <= DW'(hv_q[1]) - DW'(hv_q[0]);
      du2_q <= DW'(in_u) - DW'(hu_q[0]);
      dv2_q <= DW'(in_v) - DW'(hv_q[0]);
    end
  end

  // Operand selection for the product in progress.
  logic signed [DW-1:0] op_a, op_b;
  logic [DW-1:0]        mag_a, mag_b;

  always_comb begin
    unique case (cmd_i.sel)
      3'd0:    begin op_a = du1_q;    op_b = dv2_q; end
      3'd1:    begin op_a = dv1_q;    op_b = du2_q; end
      3'd2:    begin op_a = dp1_q[0]; op_b = dv2_q; end
      3'd3:    begin op_a = dp2_q[0]; op_b = dv1_q; end
      3'd4:    begin op_a = dp1_q[1]; op_b = dv2_q; end
      3'd5:    begin op_a = dp2_q[1]; op_b = dv1_q; end
      3'd6:    begin op_a = dp1_q[2]; op_b = dv2_q; end
      default: begin op_a = dp2_q[2]; op_b = dv1_q; end
    endcase
  end

  assign mag_a = op_a[DW-1] ? DW'(-op_a) : DW'(op_a);
  assign mag_b = op_b[DW-1] ? DW'(-op_b) : DW'(op_b);

  // Serial multiplier: one chunk of the second operand per step, top chunk first.
  logic [DW-1:0]      ma_q;
  logic [MBW-1:0]     mb_q;
  logic               msg_q;
  logic [PAW-1:0]     pacc_q;
  logic [DW+CHW-1:0]  pp;

  assign pp = ma_q * mb_q[MBW-1 -: CHW];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      ma_q   <= mag_a;
      mb_q   <= MBW'(mag_b);
      msg_q  <= op_a[DW-1] ^ op_b[DW-1];
      pacc_q <= '0;
    end else if (cmd_i.mul_step) begin
      pacc_q <= (pacc_q << CHW) + PAW'(pp);
      mb_q   <= mb_q << CHW;
    end
  end

  // Signed product and the running sum of two products.
  logic [PW-1:0]        pmag;
  logic signed [AW-1:0] pz, psig;
  logic signed [AW-1:0] acc_q;
  logic [AW-1:0]        acc_mag;

  assign pmag    = PW'(pacc_q);
  assign pz      = $signed(AW'(pmag));
  assign psig    = msg_q ? -pz : pz;
  assign acc_mag = acc_q[AW-1] ? AW'(-acc_q) : AW'(acc_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_load) begin
      acc_q <= psig;
    end else if (cmd_i.acc_sub) begin
      acc_q <= acc_q - psig;
    end
  end

  assign stat_o.det_zero = (acc_q == '0);

  // Determinant held for the three divisions.
  logic [AW-1:0] detm_q;
  logic          dsg_q;
  logic          degen_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.det_save) begin
      detm_q  <= acc_mag;
      dsg_q   <= acc_q[AW-1];
      degen_q <= (acc_q == '0);
    end
  end

  // Restoring divider, one quotient bit per step; the high part is checked for overflow first.
  logic [NW-1:0] nfull, rem0;
  logic [AW-1:0] rem_q;
  logic [C-1:0]  lown_q;
  logic [C-1:0]  quo_q;
  logic          ovf_q;
  logic          nsg_q;
  logic [AW:0]   rem2;
  logic          ge;

  assign nfull = {acc_mag, {FRAC_BITS{1'b0}}};
  assign rem0  = nfull >> C;
  assign rem2  = {rem_q, lown_q[C-1]};
  assign ge    = (rem2 >= {1'b0, detm_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q  <= AW'(rem0);
      lown_q <= nfull[C-1:0];
      quo_q  <= '0;
      ovf_q  <= (rem0 >= NW'(detm_q));
      nsg_q  <= acc_q[AW-1];
    end else if (cmd_i.div_step) begin
      rem_q  <= ge ? AW'(rem2 - {1'b0, detm_q}) : AW'(rem2);
      lown_q <= lown_q << 1;
      quo_q  <= {quo_q[C-2:0], ge};
    end
  end

  // Sign and saturation of one tangent axis.
  logic                sat_pos, sat_neg, res_neg;
  logic signed [C-1:0] res;
  logic signed [C-1:0] tan_q [3];

  assign sat_pos = ovf_q | quo_q[C-1];
  assign sat_neg = ovf_q | (quo_q[C-1] & (|quo_q[C-2:0]));
  assign res_neg = nsg_q ^ dsg_q;

  always_comb begin
    if (res_neg) begin
      res = sat_neg ? LIM_NEG : -$signed(quo_q);
    end else begin
      res = sat_pos ? LIM_POS : $signed(quo_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.axis_save) begin
      tan_q[cmd_i.axis] <= res;
    end
  end

  // Output register of the result channel.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      tangent_x_o  <= degen_q ? '0 : FW'(tan_q[0]);
      tangent_y_o  <= degen_q ? '0 : FW'(tan_q[1]);
      tangent_z_o  <= degen_q ? '0 : FW'(tan_q[2]);
      degenerate_o <= degen_q;
    end
  end

endmodule

`default_nettype wire

// ===== sv/tri_tan_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tri_tan_ctrl #(
  parameter int unsigned COORD_BITS = tri_tan_pkg::COORD_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  input  wire tri_tan_pkg::tt_stat_t stat_i,
  output      tri_tan_pkg::tt_cmd_t  cmd_o
);

  localparam int unsigned C    = COORD_BITS;
  localparam int unsigned NCH  = (C + tri_tan_pkg::CHUNK_W) / tri_tan_pkg::CHUNK_W;
  localparam int unsigned CNTW = $clog2(C + NCH + 1);

  tri_tan_pkg::tt_state_e state_q, state_d;
  logic [1:0]      corner_q;
  logic [2:0]      step_q;
  logic [CNTW-1:0] cnt_q;
  logic            out_valid_q;
  logic            in_xfer;
  logic            out_xfer;
  logic            mul_last;
  logic            div_last;

  assign in_ready_o  = (corner_q != tri_tan_pkg::CORNER_LAST) ||
                       (state_q == tri_tan_pkg::ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_xfer    = out_valid_q && out_ready_i;
  assign mul_last    = (cnt_q == CNTW'(NCH - 1));
  // One quotient bit per step until the COORD_BITS-bit quotient is complete, then the axis is saved.
  assign div_last    = (cnt_q == CNTW'(C));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tri_tan_pkg::ST_IDLE: begin
        if (in_xfer && corner_q == tri_tan_pkg::CORNER_LAST) state_d = tri_tan_pkg::ST_MUL_LD;
      end
      tri_tan_pkg::ST_MUL_LD:  state_d = tri_tan_pkg::ST_MUL_RUN;
      tri_tan_pkg::ST_MUL_RUN: begin
        if (mul_last) state_d = tri_tan_pkg::ST_ACC;
      end
      tri_tan_pkg::ST_ACC: begin
        priority if (step_q == 3'd1) state_d = tri_tan_pkg::ST_DET_CHK;
        else if (step_q[0])          state_d = tri_tan_pkg::ST_DIV_LD;
        else                         state_d = tri_tan_pkg::ST_MUL_LD;
      end
      tri_tan_pkg::ST_DET_CHK: begin
        state_d = stat_i.det_zero ? tri_tan_pkg::ST_EMIT : tri_tan_pkg::ST_MUL_LD;
      end
      tri_tan_pkg::ST_DIV_LD:  state_d = tri_tan_pkg::ST_DIV_RUN;
      tri_tan_pkg::ST_DIV_RUN: begin
        if (div_last) begin
          state_d = (step_q == tri_tan_pkg::LAST_STEP) ? tri_tan_pkg::ST_EMIT :
                                                         tri_tan_pkg::ST_MUL_LD;
        end
      end
      tri_tan_pkg::ST_EMIT: begin
        if (!out_valid_q || out_ready_i) state_d = tri_tan_pkg::ST_IDLE;
      end
      default: state_d = tri_tan_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = in_xfer;
    cmd_o.corner = corner_q;
    cmd_o.sel    = step_q;
    cmd_o.axis   = step_q[2:1] - 2'd1;
    unique case (state_q)
      tri_tan_pkg::ST_MUL_LD:  cmd_o.mul_start = 1'b1;
      tri_tan_pkg::ST_MUL_RUN: cmd_o.mul_step  = 1'b1;
      tri_tan_pkg::ST_ACC: begin
        cmd_o.acc_load = ~step_q[0];
        cmd_o.acc_sub  = step_q[0];
      end
      tri_tan_pkg::ST_DET_CHK: cmd_o.det_save  = 1'b1;
      tri_tan_pkg::ST_DIV_LD:  cmd_o.div_start = 1'b1;
      tri_tan_pkg::ST_DIV_RUN: begin
        cmd_o.div_step  = ~div_last;
        cmd_o.axis_save = div_last;
      end
      tri_tan_pkg::ST_EMIT:    cmd_o.emit = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // State, corner count, product step and cycle counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tri_tan_pkg::ST_IDLE;
      corner_q    <= '0;
      step_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        corner_q <= (corner_q == tri_tan_pkg::CORNER_LAST) ? 2'd0 : corner_q + 2'd1;
      end
      unique case (state_q)
        tri_tan_pkg::ST_IDLE:    step_q <= '0;
        tri_tan_pkg::ST_ACC:     if (!step_q[0]) step_q <= step_q + 3'd1;
        tri_tan_pkg::ST_DET_CHK: step_q <= 3'd2;
        tri_tan_pkg::ST_DIV_RUN: begin
          if (div_last && step_q != tri_tan_pkg::LAST_STEP) step_q <= step_q + 3'd1;
        end
        default: ;
      endcase
      if (state_q == tri_tan_pkg::ST_MUL_RUN || state_q == tri_tan_pkg::ST_DIV_RUN) begin
        cnt_q <= cnt_q + CNTW'(1);
      end else begin
        cnt_q <= '0;
      end
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // A result is presented right after the output register is loaded.
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> out_valid_q) else $error("result not presented after load");

  // A new result only comes from the emit state.
  a_rise_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == tri_tan_pkg::ST_EMIT))
    else $error("result appeared outside emit");

  // The deltas of a triangle in work are never overwritten by a new third corner.
  a_no_third_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != tri_tan_pkg::ST_IDLE && corner_q == tri_tan_pkg::CORNER_LAST) |-> !in_ready_o)
    else $error("third corner taken while busy");

  // Divisions only follow the second product of an axis.
  a_div_odd_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tri_tan_pkg::ST_DIV_RUN) |-> (step_q[0] && step_q != 3'd1))
    else $error("division on a wrong step");

endmodule

`default_nettype wire

// ===== sim/triangle_tangent_compute_unit_test.sv =====
`timescale 1ns / 1ps

// Scoreboard: tracks corners and predicts one tangent per completed triangle.
class tangent_scoreboard;
  logic signed [31:0] held_pos [6];
  logic signed [31:0] held_tex [4];
  int unsigned        corners;
  logic [96:0]        pending_tangents [$];
  int unsigned        fail_count;

  function new();
    corners    = 0;
    fail_count = 0;
  endfunction

  // Divide a numerator by the determinant, truncate toward zero and saturate.
  function automatic logic [31:0] axis_value(logic signed [127:0] num,
                                             logic signed [127:0] det);
    logic               neg;
    logic        [127:0] un;
    logic        [127:0] ud;
    logic        [127:0] q;
    neg = num[127] ^ det[127];
    un  = num[127] ? -num : num;
    ud  = det[127] ? -det : det;
    q   = (un << 16) / ud;
    if (!neg) begin
      if (q > 128'h7fff_ffff) q = 128'h7fff_ffff;
      return q[31:0];
    end
    if (q > 128'h8000_0000) q = 128'h8000_0000;
    return 32'(0 - q[31:0]);
  endfunction

  // Note one accepted vertex; the third of a triangle queues a tangent.
  function void note_vertex(logic signed [31:0] px, logic signed [31:0] py,
                            logic signed [31:0] pz, logic signed [31:0] u,
                            logic signed [31:0] v);
    logic signed [127:0] dp1 [3];
    logic signed [127:0] dp2 [3];
    logic signed [127:0] du1, dv1, du2, dv2, det, num;
    logic        [31:0]  t [3];
    logic signed [31:0]  cur [3];
    cur[0] = px; cur[1] = py; cur[2] = pz;
    if (corners < 2) begin
      for (int k = 0; k < 3; k++) held_pos[corners * 3 + k] = cur[k];
      held_tex[corners * 2]     = u;
      held_tex[corners * 2 + 1] = v;
      corners++;
      return;
    end
    corners = 0;
    for (int k = 0; k < 3; k++) begin
      dp1[k] = 128'(held_pos[3 + k]) - 128'(held_pos[k]);
      dp2[k] = 128'(cur[k]) - 128'(held_pos[k]);
    end
    du1 = 128'(held_tex[2]) - 128'(held_tex[0]);
    dv1 = 128'(held_tex[3]) - 128'(held_tex[1]);
    du2 = 128'(u) - 128'(held_tex[0]);
    dv2 = 128'(v) - 128'(held_tex[1]);
    det = du1 * dv2 - dv1 * du2;
    if (det == 0) begin
      pending_tangents.insert(pending_tangents.size(), {96'd0, 1'b1});
      return;
    end
    for (int k = 0; k < 3; k++) begin
      num  = dp1[k] * dv2 - dp2[k] * dv1;
      t[k] = axis_value(num, det);
    end
    pending_tangents.insert(pending_tangents.size(), {t[0], t[1], t[2], 1'b0});
  endfunction

  // Compare one received tangent with the oldest prediction.
  function void check_tangent(logic [31:0] tx, logic [31:0] ty, logic [31:0] tz,
                              logic dg);
    logic [96:0] e;
    if (pending_tangents.size() == 0) begin
      $error("unexpected tangent transfer");
      fail_count++;
      return;
    end
    e = pending_tangents.pop_front();
    if (e[96:65] !== tx) begin
      $error("tangent_x expected %h actual %h", e[96:65], tx); fail_count++;
    end
    if (e[64:33] !== ty) begin
      $error("tangent_y expected %h actual %h", e[64:33], ty); fail_count++;
    end
    if (e[32:1] !== tz) begin
      $error("tangent_z expected %h actual %h", e[32:1], tz); fail_count++;
    end
    if (e[0] !== dg) begin
      $error("degenerate expected %b actual %b", e[0], dg); fail_count++;
    end
  endfunction
endclass

module triangle_tangent_compute_unit_test;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES   = 300;

  logic clk_i;
  logic rst_ni;
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   recv_hold;
  bit   stim_done;
  int unsigned quiet_cycles;
  tangent_scoreboard board;

  tri_tan_vtx_if vtx ();
  tri_tan_res_if res ();

  triangle_tangent_compute_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vtx_i (vtx.sink),
    .res_o (res.source)
  );

  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  initial begin
    board = new();
    vtx.valid = 1'b0;
    vtx.pos_x = '0; vtx.pos_y = '0; vtx.pos_z = '0;
    vtx.tex_u = '0; vtx.tex_v = '0;
    res.ready = 1'b0;
    send_idle_pct = 28;
    recv_idle_pct = 66;
    recv_hold = 1'b0;
    stim_done = 1'b0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Receiver: random ready, or held low during a long hold-off.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      res.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitors: note vertex transfers and check result transfers.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (vtx.valid && vtx.ready) begin
        board.note_vertex(vtx.pos_x, vtx.pos_y, vtx.pos_z, vtx.tex_u, vtx.tex_v);
      end
      if (res.valid && res.ready) begin
        board.check_tangent(res.tangent_x, res.tangent_y, res.tangent_z,
                            res.degenerate);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((vtx.valid && vtx.ready) || (res.valid && res.ready) || !rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("triangle_tangent_compute_unit_test: FAIL");
        $finish;
      end
    end
  end

  // Pick a field value: extremes, small values, or fully random.
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(8)) - 4) << 16;
      3, 4: return 32'(int'($urandom_range(2000)) - 1000) << 12;
      default: return $urandom();
    endcase
  endfunction

  // Offer one vertex and wait for its transfer, idling first at random.
  task automatic send_vertex(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [31:0] u, logic [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      vtx.valid <= 1'b0;
      @(posedge clk_i);
    end
    vtx.valid <= 1'b1;
    vtx.pos_x <= px; vtx.pos_y <= py; vtx.pos_z <= pz;
    vtx.tex_u <= u;  vtx.tex_v <= v;
    @(posedge clk_i);
    while (!vtx.ready) @(posedge clk_i);
  endtask

  task automatic send_random_vertex();
    send_vertex(pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord());
  endtask

  // Stimulus.
  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    // Right triangle with unit UVs, then a degenerate one of equal UVs.
    send_vertex(0, 0, 0, 0, 0);
    send_vertex(32'h0001_0000, 0, 0, 32'h0001_0000, 0);
    send_vertex(0, 32'h0001_0000, 0, 0, 32'h0001_0000);
    send_vertex(5, 6, 7, 32'h0002_0000, 32'h0002_0000);
    send_vertex(8, 9, 1, 32'h0002_0000, 32'h0002_0000);
    send_vertex(3, 2, 1, 32'h0002_0000, 32'h0002_0000);
    // Extremes to force saturation both ways.
    send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, 0);
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1, 0);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 0, 1);
    send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h8000_0000, 32'h8000_0000);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7fff_ffff, 32'h8000_0000);
    send_vertex(32'hffff_ffff, 0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_vertex('1, '1, '1, '1, '1);
    send_vertex(0, 0, 0, '1, 0);
    send_vertex(0, 0, 0, 0, '1);
    // Random phases with changing idle mix.
    for (int i = 0; i < 840; i++) begin
      if (i == 280) begin
        send_idle_pct = 66; recv_idle_pct = 28;
      end
      if (i == 560) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      if (i == 600) recv_hold = 1'b1;
      send_random_vertex();
    end
    // Trailing partial triangle gives nothing.
    send_vertex(1, 2, 3, 4, 5);
    vtx.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Long receiver hold-off while the sender keeps offering vertices.
  initial begin
    wait (recv_hold);
    repeat (2000) @(posedge clk_i);
    recv_hold = 1'b0;
  end

  // End of run.
  initial begin
    wait (stim_done);
    while (board.pending_tangents.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.fail_count == 0 && board.pending_tangents.size() == 0) begin
      $display("triangle_tangent_compute_unit_test: PASS");
    end else begin
      $display("triangle_tangent_compute_unit_test: FAIL");
    end
    $finish;
  end
endmodule

// ===== files.f =====
sv/tri_tan_pkg.sv
sv/tri_tan_ifs.sv
sv/tri_tan_datapath.sv
sv/tri_tan_ctrl.sv
sv/triangle_tangent_compute_unit.sv
sim/triangle_tangent_compute_unit_test.sv
